/* rtl/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and shared types.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_message;
    } t_req;

    localparam int QDEPTH = 4;

    localparam t_word INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

/* rtl/sha256_front.sv */
// ----------------------------------------------------------------------------
// SHA-256 front queue
// Takes input requests, drops idle ones and queues the rest for the core.
// ----------------------------------------------------------------------------
module sha256_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  sha256_pkg::t_req  i_req,
    output logic              o_avail,
    output sha256_pkg::t_req  o_req,
    input  logic              i_take
);
    localparam int AW = $clog2(sha256_pkg::QDEPTH);

    sha256_pkg::t_req r_mem [sha256_pkg::QDEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [AW:0]   r_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == (AW+1)'(sha256_pkg::QDEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_req   = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full && (i_req.byte_valid || i_req.end_message);
    assign w_rd    = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) r_wptr <= r_wptr + 1'b1;
            if (w_rd) r_rptr <= r_rptr + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !w_wr) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_avail |-> !w_rd) else $error("queue underflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd && r_cnt != (AW+1)'(sha256_pkg::QDEPTH)) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("count slip");
`endif
endmodule

/* rtl/sha256_core.sv */
// ----------------------------------------------------------------------------
// SHA-256 core
// Buffers bytes, pads, runs one round per cycle and emits digest parts.
// ----------------------------------------------------------------------------
module sha256_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  sha256_pkg::t_req  i_req,
    output logic              o_take,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [63:0]       o_digest_part,
    output logic [1:0]        o_part_index,
    output logic              o_last_part
);
    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_ROUND, S_ADD, S_PAD, S_OUT} t_state;

    t_state              r_state;
    logic [31:0]         r_buf [16];
    logic [5:0]          r_fill;
    logic [63:0]         r_msg;
    sha256_pkg::t_word   r_h [8];
    sha256_pkg::t_word   r_v [8];
    sha256_pkg::t_word   r_w [16];
    logic [5:0]          r_rnd;
    logic [3:0]          r_lidx;
    logic [5:0]          r_pidx;
    logic                r_fin;
    logic                r_second;
    logic                r_padded;
    logic [1:0]          r_part;

    sha256_pkg::t_word w_wnew, w_wi, w_t1, w_t2, w_s0, w_s1, w_ch, w_mj;
    logic [5:0] w_bidx;
    logic [7:0] w_pbyte;
    logic [63:0] w_bits;

    function automatic sha256_pkg::t_word ror(sha256_pkg::t_word x, int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    assign o_take = (r_state == S_IDLE) && i_avail;
    assign o_empty = (r_state != S_OUT);
    assign o_digest_part = {r_h[{r_part, 1'b0}], r_h[{r_part, 1'b1}]};
    assign o_part_index = r_part;
    assign o_last_part = (r_part == 2'd3);
    assign w_bits = r_msg << 3;

    always_comb begin
        w_s0 = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
        w_s1 = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
        w_wnew = r_w[0] + w_s0 + r_w[9] + w_s1;
        w_wi = (r_rnd < 6'd16) ? r_w[0] : w_wnew;
        w_ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_t1 = r_v[7] + (ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25))
             + w_ch + sha256_pkg::ROUND_K[r_rnd] + w_wi;
        w_t2 = (ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22)) + w_mj;
        w_bidx = r_pidx;
        if (!r_second && w_bidx == r_fill) begin
            w_pbyte = 8'h80;
        end else if (w_bidx >= 6'd56 && (r_second || r_fill < 6'd56)) begin
            w_pbyte = w_bits[{~w_bidx[2:0], 3'b111} -: 8];
        end else if (w_bidx > r_fill || r_second) begin
            w_pbyte = 8'h00;
        end else begin
            w_pbyte = r_buf[w_bidx[5:2]][{~w_bidx[1:0], 3'b000} +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0;
            r_msg <= '0;
            r_fin <= 1'b0;
            r_second <= 1'b0;
            r_padded <= 1'b0;
            r_part <= '0;
            r_rnd <= '0;
            r_lidx <= '0;
            r_pidx <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::INIT_H[i];
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        r_fin <= i_req.end_message;
                        r_second <= 1'b0;
                        r_padded <= 1'b0;
                        r_pidx <= '0;
                        if (i_req.byte_valid) begin
                            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_req.data_byte;
                            r_msg <= r_msg + 64'd1;
                            r_fill <= r_fill + 6'd1;
                            if (r_fill == 6'd63) begin
                                r_lidx <= '0;
                                r_state <= S_LOAD;
                            end else if (i_req.end_message) begin
                                r_state <= S_PAD;
                            end
                        end else begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_buf[w_bidx[5:2]][{~w_bidx[1:0], 3'b000} +: 8] <= w_pbyte;
                    r_padded <= 1'b1;
                    r_pidx <= r_pidx + 6'd1;
                    if (r_pidx == 6'd63) begin
                        r_lidx <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= r_buf[r_lidx];
                    r_lidx <= r_lidx + 4'd1;
                    if (r_lidx == 4'd15) begin
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        r_rnd <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_wi;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_pidx <= '0;
                    if (!r_fin) begin
                        r_fill <= '0;
                        r_state <= S_IDLE;
                    end else if (!r_padded) begin
                        r_state <= S_PAD;
                    end else if (!r_second && r_fill >= 6'd56) begin
                        r_second <= 1'b1;
                        r_state <= S_PAD;
                    end else begin
                        r_part <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_pop) begin
                        r_part <= r_part + 2'd1;
                        if (r_part == 2'd3) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::INIT_H[i];
                            r_fill <= '0;
                            r_msg <= '0;
                            r_fin <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> !o_empty && $stable(r_part)) else $error("part moved");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> r_state == S_IDLE) else $error("take outside idle");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && o_last_part) |=> o_empty) else $error("extra part");
`endif
endmodule

/* rtl/sha256_message_digest.sv */
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Byte-stream SHA-256 with a request queue in front of a round engine.
// ----------------------------------------------------------------------------
// Input channel: drive i_data_byte, i_byte_valid, i_end_message with i_push;
// a request is taken when i_push is high and o_full is low. Requests with
// neither a byte nor an end flag are dropped at once.
// Output channel: while o_empty is low the oldest digest part is shown;
// i_pop takes it. Each finished message gives four parts, index 0 first.
// Processing: the core takes bytes only while idle; the 64th byte of a block
// starts the schedule load, the rounds and the final add. Ending a message
// adds a padding pass and a compression, twice when the last block holds
// 56 to 63 bytes. The single shared round unit sets the throughput.
// The four-entry queue lets requests keep coming while the core is busy.
// A stalled receiver holds the core in its output state; the queue fills
// and then o_full rises. Reset is synchronous and empties the queue and
// restores the initial hash values.
// ----------------------------------------------------------------------------
module sha256_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_message,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [63:0] o_digest_part,
    output logic [1:0]  o_part_index,
    output logic        o_last_part
);
    sha256_pkg::t_req w_in, w_q;
    logic w_avail, w_take;

    assign w_in = '{data_byte: i_data_byte, byte_valid: i_byte_valid,
                    end_message: i_end_message};

    sha256_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_req(w_in), .o_avail(w_avail), .o_req(w_q), .i_take(w_take)
    );

    sha256_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(w_avail), .i_req(w_q),
        .o_take(w_take), .o_empty(o_empty), .i_pop(i_pop),
        .o_digest_part(o_digest_part), .o_part_index(o_part_index),
        .o_last_part(o_last_part)
    );
endmodule
